@@ hw/rtl/fdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the evaluation program for the frame direction
// cosine core.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int ValW      = 34;
  localparam int TableLen  = 24;
  localparam int NumAngles = 5;
  localparam int NumTrig   = 2 * NumAngles;
  localparam int NumLoads  = NumTrig;
  localparam int RfDepth   = 16;

  typedef logic signed [ValW-1:0] fdc_val_t;

  localparam fdc_val_t HalfPi = 34'sh0_6487_ED51;
  localparam fdc_val_t Pi     = 34'sh0_C90F_DAA2;
  localparam fdc_val_t Gain   = 34'sh0_26DD_3B6A;

  localparam logic [3:0] LastComp = 4'd14;

  // register file slots: sines and cosines first, then scratch
  localparam logic [3:0] R_SB1 = 4'd0;
  localparam logic [3:0] R_CB1 = 4'd1;
  localparam logic [3:0] R_SB2 = 4'd2;
  localparam logic [3:0] R_CB2 = 4'd3;
  localparam logic [3:0] R_SP  = 4'd4;
  localparam logic [3:0] R_CP  = 4'd5;
  localparam logic [3:0] R_SC1 = 4'd6;
  localparam logic [3:0] R_CC1 = 4'd7;
  localparam logic [3:0] R_SC2 = 4'd8;
  localparam logic [3:0] R_CC2 = 4'd9;
  localparam logic [3:0] T0    = 4'd10;
  localparam logic [3:0] T1    = 4'd11;
  localparam logic [3:0] T2    = 4'd12;
  localparam logic [3:0] T3    = 4'd13;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_MUL  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_NEG  = 3'd4,
    OP_OUT  = 3'd5
  } fdc_op_e;

  typedef struct packed {
    fdc_op_e    op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] comp;
  } fdc_instr_t;

  typedef struct packed {
    logic     valid;
    logic     neg;
    fdc_val_t x;
    fdc_val_t y;
    fdc_val_t z;
  } fdc_cdc_t;

  typedef struct packed {
    logic       release_bank;
    logic [3:0] idx;
  } fdc_bank_req_t;

  function automatic fdc_val_t fdc_atan(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return fdc_val_t'({2'b00, v});
  endfunction

  function automatic fdc_instr_t mk(input fdc_op_e op, input logic [3:0] d,
                                    input logic [3:0] a, input logic [3:0] b,
                                    input logic [3:0] c);
    fdc_instr_t r;
    r.op = op;
    r.dst = d;
    r.a = a;
    r.b = b;
    r.comp = c;
    return r;
  endfunction

  function automatic fdc_instr_t mul(input logic [3:0] d, input logic [3:0] a,
                                     input logic [3:0] b);
    return mk(OP_MUL, d, a, b, 4'd0);
  endfunction

  function automatic fdc_instr_t add(input logic [3:0] d, input logic [3:0] a,
                                     input logic [3:0] b);
    return mk(OP_ADD, d, a, b, 4'd0);
  endfunction

  function automatic fdc_instr_t sub(input logic [3:0] d, input logic [3:0] a,
                                     input logic [3:0] b);
    return mk(OP_SUB, d, a, b, 4'd0);
  endfunction

  function automatic fdc_instr_t emit(input logic [3:0] a, input logic [3:0] c);
    return mk(OP_OUT, 4'd0, a, a, c);
  endfunction

  // program: copy the ten sines and cosines in, then evaluate the 15 results
  function automatic fdc_instr_t fdc_prog(input logic [7:0] pc);
    fdc_instr_t i;
    case (pc)
      8'd0:   i = mk(OP_LOAD, R_SB1, R_SB1, R_SB1, 4'd0);
      8'd1:   i = mk(OP_LOAD, R_CB1, R_CB1, R_CB1, 4'd0);
      8'd2:   i = mk(OP_LOAD, R_SB2, R_SB2, R_SB2, 4'd0);
      8'd3:   i = mk(OP_LOAD, R_CB2, R_CB2, R_CB2, 4'd0);
      8'd4:   i = mk(OP_LOAD, R_SP, R_SP, R_SP, 4'd0);
      8'd5:   i = mk(OP_LOAD, R_CP, R_CP, R_CP, 4'd0);
      8'd6:   i = mk(OP_LOAD, R_SC1, R_SC1, R_SC1, 4'd0);
      8'd7:   i = mk(OP_LOAD, R_CC1, R_CC1, R_CC1, 4'd0);
      8'd8:   i = mk(OP_LOAD, R_SC2, R_SC2, R_SC2, 4'd0);
      8'd9:   i = mk(OP_LOAD, R_CC2, R_CC2, R_CC2, 4'd0);
      // frame a
      8'd10:  i = emit(R_CB1, 4'd0);
      8'd11:  i = mul(T0, R_SB1, R_SC1);
      8'd12:  i = emit(T0, 4'd1);
      8'd13:  i = mul(T0, R_CC1, R_SB1);
      8'd14:  i = emit(T0, 4'd2);
      // frame b, negated
      8'd15:  i = mk(OP_NEG, T0, R_CB2, R_CB2, 4'd0);
      8'd16:  i = emit(T0, 4'd3);
      8'd17:  i = mul(T0, R_SB2, R_SC2);
      8'd18:  i = mk(OP_NEG, T0, T0, T0, 4'd0);
      8'd19:  i = emit(T0, 4'd4);
      8'd20:  i = mul(T0, R_CC2, R_SB2);
      8'd21:  i = mk(OP_NEG, T0, T0, T0, 4'd0);
      8'd22:  i = emit(T0, 4'd5);
      // zz
      8'd23:  i = mul(T0, R_CB1, R_CB2);
      8'd24:  i = mul(T1, R_CP, R_SB1);
      8'd25:  i = mul(T1, T1, R_SB2);
      8'd26:  i = add(T0, T0, T1);
      8'd27:  i = emit(T0, 4'd6);
      // zx
      8'd28:  i = mul(T0, R_CC2, R_SP);
      8'd29:  i = mul(T0, T0, R_SB1);
      8'd30:  i = mul(T1, R_CP, R_CB2);
      8'd31:  i = mul(T1, T1, R_SB1);
      8'd32:  i = mul(T2, R_CB1, R_SB2);
      8'd33:  i = sub(T2, T2, T1);
      8'd34:  i = mul(T2, T2, R_SC2);
      8'd35:  i = add(T0, T0, T2);
      8'd36:  i = emit(T0, 4'd7);
      // zy
      8'd37:  i = mul(T0, R_CP, R_CB2);
      8'd38:  i = mul(T0, T0, R_CC2);
      8'd39:  i = mul(T0, T0, R_SB1);
      8'd40:  i = mul(T1, R_CB1, R_CC2);
      8'd41:  i = mul(T1, T1, R_SB2);
      8'd42:  i = sub(T1, T1, T0);
      8'd43:  i = mul(T2, R_SP, R_SB1);
      8'd44:  i = mul(T2, T2, R_SC2);
      8'd45:  i = sub(T1, T1, T2);
      8'd46:  i = emit(T1, 4'd8);
      // xz
      8'd47:  i = mul(T0, R_CB2, R_SB1);
      8'd48:  i = mul(T0, T0, R_SC1);
      8'd49:  i = mul(T1, R_CC1, R_SP);
      8'd50:  i = mul(T2, R_CP, R_CB1);
      8'd51:  i = mul(T2, T2, R_SC1);
      8'd52:  i = add(T1, T1, T2);
      8'd53:  i = mul(T1, R_SB2, T1);
      8'd54:  i = sub(T0, T0, T1);
      8'd55:  i = emit(T0, 4'd9);
      // xx
      8'd56:  i = mul(T0, R_CB1, R_CC2);
      8'd57:  i = mul(T0, T0, R_SP);
      8'd58:  i = mul(T0, T0, R_SC1);
      8'd59:  i = mul(T1, R_CB2, R_CC1);
      8'd60:  i = mul(T1, T1, R_SP);
      8'd61:  i = mul(T2, R_SB1, R_SB2);
      8'd62:  i = mul(T2, T2, R_SC1);
      8'd63:  i = add(T1, T1, T2);
      8'd64:  i = mul(T1, T1, R_SC2);
      8'd65:  i = sub(T1, T1, T0);
      8'd66:  i = mul(T2, R_CC1, R_CC2);
      8'd67:  i = mul(T3, R_CB1, R_CB2);
      8'd68:  i = mul(T3, T3, R_SC1);
      8'd69:  i = mul(T3, T3, R_SC2);
      8'd70:  i = add(T2, T2, T3);
      8'd71:  i = mul(T2, R_CP, T2);
      8'd72:  i = add(T1, T1, T2);
      8'd73:  i = emit(T1, 4'd10);
      // xy
      8'd74:  i = mul(T0, R_CC2, R_SB1);
      8'd75:  i = mul(T0, T0, R_SB2);
      8'd76:  i = mul(T0, T0, R_SC1);
      8'd77:  i = mul(T1, R_CC1, R_SP);
      8'd78:  i = mul(T2, R_CP, R_CB1);
      8'd79:  i = mul(T2, T2, R_SC1);
      8'd80:  i = add(T1, T1, T2);
      8'd81:  i = mul(T2, R_CB2, R_CC2);
      8'd82:  i = mul(T2, T2, T1);
      8'd83:  i = add(T0, T0, T2);
      8'd84:  i = mul(T1, R_CP, R_CC1);
      8'd85:  i = mul(T2, R_CB1, R_SP);
      8'd86:  i = mul(T2, T2, R_SC1);
      8'd87:  i = sub(T2, T2, T1);
      8'd88:  i = mul(T2, T2, R_SC2);
      8'd89:  i = add(T0, T0, T2);
      8'd90:  i = emit(T0, 4'd11);
      // yz
      8'd91:  i = mul(T0, R_CB2, R_CC1);
      8'd92:  i = mul(T0, T0, R_SB1);
      8'd93:  i = mul(T1, R_CP, R_CB1);
      8'd94:  i = mul(T1, T1, R_CC1);
      8'd95:  i = mul(T2, R_SP, R_SC1);
      8'd96:  i = sub(T2, T2, T1);
      8'd97:  i = mul(T2, R_SB2, T2);
      8'd98:  i = add(T0, T0, T2);
      8'd99:  i = emit(T0, 4'd12);
      // yx
      8'd100: i = mul(T0, R_CC1, R_SB1);
      8'd101: i = mul(T0, T0, R_SB2);
      8'd102: i = mul(T0, T0, R_SC2);
      8'd103: i = mul(T1, R_CC2, R_SP);
      8'd104: i = mul(T2, R_CP, R_CB2);
      8'd105: i = mul(T2, T2, R_SC2);
      8'd106: i = sub(T2, T2, T1);
      8'd107: i = mul(T3, R_CB1, R_CC1);
      8'd108: i = mul(T3, T3, T2);
      8'd109: i = add(T0, T0, T3);
      8'd110: i = mul(T1, R_CP, R_CC2);
      8'd111: i = mul(T2, R_CB2, R_SP);
      8'd112: i = mul(T2, T2, R_SC2);
      8'd113: i = add(T1, T1, T2);
      8'd114: i = mul(T1, R_SC1, T1);
      8'd115: i = sub(T0, T0, T1);
      8'd116: i = emit(T0, 4'd13);
      // yy
      8'd117: i = mul(T0, R_CB2, R_CC2);
      8'd118: i = mul(T0, T0, R_SP);
      8'd119: i = mul(T0, T0, R_SC1);
      8'd120: i = mul(T1, R_CC2, R_SB1);
      8'd121: i = mul(T1, T1, R_SB2);
      8'd122: i = mul(T2, R_CB1, R_SP);
      8'd123: i = mul(T2, T2, R_SC2);
      8'd124: i = add(T1, T1, T2);
      8'd125: i = mul(T1, R_CC1, T1);
      8'd126: i = sub(T1, T1, T0);
      8'd127: i = mul(T2, R_CB1, R_CB2);
      8'd128: i = mul(T2, T2, R_CC1);
      8'd129: i = mul(T2, T2, R_CC2);
      8'd130: i = mul(T3, R_SC1, R_SC2);
      8'd131: i = add(T2, T2, T3);
      8'd132: i = mul(T2, R_CP, T2);
      8'd133: i = add(T1, T1, T2);
      8'd134: i = emit(T1, LastComp);
      default: i = mk(OP_NEG, T3, T3, T3, 4'd0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/frame_direction_cosines_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_direction_cosines_core
// Sines and cosines of five angles through a CORDIC cell chain, then the
// frame projections and cross-frame direction cosines, fifteen results per item.
// ----------------------------------------------------------------------------
// sequence: the angles pass through the CORDIC cell chain, one cell per
// iteration; then each step of the 135-step program goes through the read,
// execute and write-back states of the shared multiply/add unit, up to the
// last of 15 results. The single multiply/add unit sets the item rate, and
// results that are stalled slow it further; the next item is taken and run
// through the chain while results are produced.
// reset: asynchronous active low; clears all valid and control state.
module frame_direction_cosines_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] angle_b1_i,
  input  wire logic signed [15:0] angle_b2_i,
  input  wire logic signed [15:0] angle_phi_i,
  input  wire logic signed [15:0] angle_c1_i,
  input  wire logic signed [15:0] angle_c2_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              component_o,
  output logic signed [15:0]      cosine_value_o,
  output logic                    last_o
);
  import fdc_pkg::*;

  localparam int NIter = (CORDIC_ITERATIONS > TableLen) ? TableLen : CORDIC_ITERATIONS;

  logic               in_hold_q;
  logic signed [15:0] angle_q [NumAngles];
  logic               feeding_q;
  logic               busy_q;
  logic [2:0]         feed_cnt_q;
  logic [2:0]         out_cnt_q;
  logic               bank_full_q;
  fdc_val_t           bank_q [NumTrig];
  logic               start_feed;
  logic               in_acc;

  fdc_cdc_t           chain [NIter+1];
  fdc_val_t           z_raw;
  fdc_val_t           sin_v, cos_v;
  fdc_bank_req_t      bank_req;
  logic               last_out;

  assign in_ready_o = !in_hold_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign start_feed = in_hold_q && !feeding_q && !busy_q && !bank_full_q;

  // quadrant fold of the angle entering the chain
  assign z_raw = fdc_val_t'(angle_q[feed_cnt_q]) <<< 17;
  always_comb begin
    chain[0].valid = feeding_q;
    chain[0].x     = Gain;
    chain[0].y     = '0;
    chain[0].neg   = 1'b0;
    chain[0].z     = z_raw;
    if (z_raw > HalfPi) begin
      chain[0].z   = z_raw - Pi;
      chain[0].neg = 1'b1;
    end else if (z_raw < -HalfPi) begin
      chain[0].z   = z_raw + Pi;
      chain[0].neg = 1'b1;
    end
  end

  for (genvar g = 0; g < NIter; g++) begin : g_cell
    fdc_cordic_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign sin_v    = chain[NIter].neg ? -chain[NIter].y : chain[NIter].y;
  assign cos_v    = chain[NIter].neg ? -chain[NIter].x : chain[NIter].x;
  assign last_out = chain[NIter].valid && (out_cnt_q == 3'(NumAngles - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hold_q   <= 1'b0;
      feeding_q   <= 1'b0;
      busy_q      <= 1'b0;
      feed_cnt_q  <= '0;
      out_cnt_q   <= '0;
      bank_full_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_hold_q <= 1'b1;
      end else if (feeding_q && feed_cnt_q == 3'(NumAngles - 1)) begin
        in_hold_q <= 1'b0;
      end
      if (start_feed) begin
        feeding_q  <= 1'b1;
        busy_q     <= 1'b1;
        feed_cnt_q <= '0;
      end else if (feeding_q) begin
        if (feed_cnt_q == 3'(NumAngles - 1)) begin
          feeding_q <= 1'b0;
        end
        feed_cnt_q <= feed_cnt_q + 3'd1;
      end
      if (chain[NIter].valid) begin
        out_cnt_q <= last_out ? 3'd0 : out_cnt_q + 3'd1;
      end
      if (last_out) begin
        busy_q      <= 1'b0;
        bank_full_q <= 1'b1;
      end else if (bank_req.release_bank) begin
        bank_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      angle_q[0] <= angle_b1_i;
      angle_q[1] <= angle_b2_i;
      angle_q[2] <= angle_phi_i;
      angle_q[3] <= angle_c1_i;
      angle_q[4] <= angle_c2_i;
    end
    if (chain[NIter].valid) begin
      bank_q[{out_cnt_q, 1'b0}] <= sin_v;
      bank_q[{out_cnt_q, 1'b1}] <= cos_v;
    end
  end

  fdc_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bank_full_i    (bank_full_q),
    .bank_data_i    (bank_q[bank_req.idx]),
    .bank_req_o     (bank_req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .component_o    (component_o),
    .cosine_value_o (cosine_value_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/fdc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_ram
// Generic register-file RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fdc_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/fdc_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_cordic_cell
// One CORDIC rotation step; hands its rotated vector to the next cell.
// ----------------------------------------------------------------------------
module fdc_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdc_pkg::fdc_cdc_t cell_i,
  output fdc_pkg::fdc_cdc_t      cell_o
);
  import fdc_pkg::*;

  localparam fdc_val_t Atan = fdc_atan(IDX);

  fdc_val_t xs, ys;
  fdc_cdc_t cell_d, cell_q;
  logic     valid_q;

  assign xs = cell_i.x >>> IDX;
  assign ys = cell_i.y >>> IDX;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[ValW-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - Atan;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/fdc_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_engine
// Sequenced multiply/add unit that evaluates the 15 direction cosines.
// ----------------------------------------------------------------------------
module fdc_engine (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   bank_full_i,
  input  wire fdc_pkg::fdc_val_t      bank_data_i,
  output fdc_pkg::fdc_bank_req_t      bank_req_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  component_o,
  output logic signed [15:0]          cosine_value_o,
  output logic                        last_o
);
  import fdc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EX   = 4'b0100,
    S_WB   = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] pc_q, pc_d;
  fdc_instr_t ins;
  fdc_val_t   rd_a, rd_b, res_q, res_d;
  logic       we;
  logic       slot_free;
  logic       emit_now;

  logic signed [2*ValW-1:0] prod;
  logic signed [2*ValW-1:0] prod_rnd;
  fdc_val_t                 q14_rnd;
  logic signed [17:0]       q14_wide;
  logic signed [15:0]       q14;

  logic              out_valid_q;
  logic [3:0]        comp_q;
  logic signed [15:0] val_q;
  logic              last_q;

  assign ins = fdc_prog(pc_q);

  fdc_ram #(.WIDTH(ValW), .DEPTH(RfDepth)) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (ins.dst),
    .wdata_i   (res_q),
    .raddr_a_i (ins.a),
    .raddr_b_i (ins.b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // rounded q3.30 product, floor shift
  assign prod     = rd_a * rd_b;
  assign prod_rnd = (prod + (68'sd1 <<< 29)) >>> 30;

  // q3.30 to q1.14 with saturation
  assign q14_rnd  = (rd_a + 34'sd32768) >>> 16;
  assign q14_wide = q14_rnd[17:0];
  always_comb begin
    if (q14_wide > 18'sd16384) begin
      q14 = 16'sd16384;
    end else if (q14_wide < -18'sd16384) begin
      q14 = -16'sd16384;
    end else begin
      q14 = q14_wide[15:0];
    end
  end

  always_comb begin
    case (ins.op)
      OP_LOAD: res_d = bank_data_i;
      OP_MUL:  res_d = prod_rnd[ValW-1:0];
      OP_ADD:  res_d = rd_a + rd_b;
      OP_SUB:  res_d = rd_a - rd_b;
      OP_NEG:  res_d = -rd_a;
      OP_OUT:  res_d = fdc_val_t'(q14);
      default: res_d = rd_a;
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_now  = (state_q == S_WB) && (ins.op == OP_OUT) && slot_free;
  assign we        = (state_q == S_WB) && (ins.op != OP_OUT);

  assign bank_req_o.idx          = ins.a;
  assign bank_req_o.release_bank = (state_q == S_WB) && (ins.op == OP_LOAD) &&
                                   (pc_q == 8'(NumLoads - 1));

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      S_IDLE: begin
        if (bank_full_i) begin
          pc_d    = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_EX;
      S_EX: state_d = S_WB;
      S_WB: begin
        if (ins.op != OP_OUT) begin
          pc_d    = pc_q + 8'd1;
          state_d = S_RD;
        end else if (slot_free) begin
          pc_d    = pc_q + 8'd1;
          state_d = (ins.comp == LastComp) ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EX) begin
      res_q <= res_d;
    end
    if (emit_now) begin
      comp_q <= ins.comp;
      val_q  <= res_q[15:0];
      last_q <= (ins.comp == LastComp);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign component_o    = comp_q;
  assign cosine_value_o = val_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

@@ hw/rtl/fdc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks for the frame direction cosine core.
// ----------------------------------------------------------------------------
module fdc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [3:0]         component_o,
  input wire logic signed [15:0] cosine_value_o,
  input wire logic               last_o
);

  // a stalled item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(component_o) && $stable(cosine_value_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // last marks the fifteenth result only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (component_o == 4'd14)))
    else $error("last flag does not match component");

  // results stay within plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cosine_value_o <= 16'sd16384) && (cosine_value_o >= -16'sd16384))
    else $error("result outside saturation range");

  // an accepted item fills the input holding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted without being held");

endmodule

bind frame_direction_cosines_core fdc_checker u_fdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .component_o    (component_o),
  .cosine_value_o (cosine_value_o),
  .last_o         (last_o)
);
`default_nettype wire

@@ bench/frame_direction_cosines_core_tb.sv @@
// ----------------------------------------------------------------------------
// frame_direction_cosines_core_tb
// Drives angle sets through the core and checks all fifteen projections and
// cross-frame cosines of each against a fixed-point CORDIC prediction.
// ----------------------------------------------------------------------------
module frame_direction_cosines_core_tb;

  localparam int Iters = 16;
  localparam int NumComp = 15;
  localparam logic [3:0] LastComp = 4'd14;

  typedef struct {
    logic signed [15:0] b1, b2, phi, c1, c2;
  } angles_t;

  typedef struct {
    logic [3:0]         comp;
    logic signed [15:0] value;
    logic               last;
  } cosine_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] angle_b1_i = '0, angle_b2_i = '0, angle_phi_i = '0;
  logic signed [15:0] angle_c1_i = '0, angle_c2_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] component_o;
  logic signed [15:0] cosine_value_o;
  logic last_o;

  angles_t pending_angles[$];
  cosine_t expected_cosines[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 73;

  frame_direction_cosines_core #(.CORDIC_ITERATIONS(Iters)) dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mq(longint a, longint b);
    return asr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint m3(longint a, longint b, longint c);
    return mq(mq(a, b), c);
  endfunction

  function automatic longint m4(longint a, longint b, longint c, longint d);
    return mq(m3(a, b, c), d);
  endfunction

  function automatic longint atan_q30(int i);
    longint tbl[24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
    return tbl[i];
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint s,
                               output longint c);
    longint z, x, y, xs, ys;
    bit neg;
    int n;
    z = longint'(ang) * 131072;
    x = 64'sh26DD3B6A;
    y = 0;
    neg = 1'b0;
    n = (Iters > 24) ? 24 : Iters;
    if (z > 64'sh6487ED51) begin
      z -= 64'shC90FDAA2;
      neg = 1'b1;
    end else if (z < -64'sh6487ED51) begin
      z += 64'shC90FDAA2;
      neg = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q30(i);
      end else begin
        x += ys; y -= xs; z += atan_q30(i);
      end
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endtask

  function automatic logic signed [15:0] to_q14(longint v);
    longint r;
    r = asr(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic predict_cosines(input angles_t a);
    longint sb1, cb1, sb2, cb2, sp, cp, sc1, cc1, sc2, cc2;
    longint r[NumComp];
    cosine_t e;
    cordic_sincos(a.b1, sb1, cb1);
    cordic_sincos(a.b2, sb2, cb2);
    cordic_sincos(a.phi, sp, cp);
    cordic_sincos(a.c1, sc1, cc1);
    cordic_sincos(a.c2, sc2, cc2);
    r[0] = cb1;
    r[1] = mq(sb1, sc1);
    r[2] = mq(cc1, sb1);
    r[3] = -cb2;
    r[4] = -mq(sb2, sc2);
    r[5] = -mq(cc2, sb2);
    r[6] = mq(cb1, cb2) + m3(cp, sb1, sb2);
    r[7] = m3(cc2, sp, sb1) + mq(-m3(cp, cb2, sb1) + mq(cb1, sb2), sc2);
    r[8] = -m4(cp, cb2, cc2, sb1) + m3(cb1, cc2, sb2) - m3(sp, sb1, sc2);
    r[9] = m3(cb2, sb1, sc1) - mq(sb2, mq(cc1, sp) + m3(cp, cb1, sc1));
    r[10] = -m4(cb1, cc2, sp, sc1)
          + mq(m3(cb2, cc1, sp) + m3(sb1, sb2, sc1), sc2)
          + mq(cp, mq(cc1, cc2) + m4(cb1, cb2, sc1, sc2));
    r[11] = m4(cc2, sb1, sb2, sc1)
          + m3(cb2, cc2, mq(cc1, sp) + m3(cp, cb1, sc1))
          + mq(-mq(cp, cc1) + m3(cb1, sp, sc1), sc2);
    r[12] = m3(cb2, cc1, sb1) + mq(sb2, -m3(cp, cb1, cc1) + mq(sp, sc1));
    r[13] = m4(cc1, sb1, sb2, sc2)
          + m3(cb1, cc1, -mq(cc2, sp) + m3(cp, cb2, sc2))
          - mq(sc1, mq(cp, cc2) + m3(cb2, sp, sc2));
    r[14] = -m4(cb2, cc2, sp, sc1)
          + mq(cc1, m3(cc2, sb1, sb2) + m3(cb1, sp, sc2))
          + mq(cp, mq(m3(cb1, cb2, cc1), cc2) + mq(sc1, sc2));
    for (int k = 0; k < NumComp; k++) begin
      e.comp = 4'(k);
      e.value = to_q14(r[k]);
      e.last = (4'(k) == LastComp);
      expected_cosines.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what,
             got, want);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(12868 + $urandom_range(0, 2) - 1);   // near +pi/2
      3: return 16'(-12868 + $urandom_range(0, 2) - 1);  // near -pi/2
      4: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_angles(input logic signed [15:0] b1, b2, phi, c1, c2);
    angles_t a;
    a.b1 = b1; a.b2 = b2; a.phi = phi; a.c1 = c1; a.c2 = c2;
    pending_angles.push_back(a);
  endtask

  // driver
  always @(posedge clk_i) begin
    angles_t a;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_cosines('{angle_b1_i, angle_b2_i, angle_phi_i, angle_c1_i, angle_c2_i});
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_angles.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          a = pending_angles.pop_front();
          in_valid_i <= 1'b1;
          angle_b1_i <= a.b1;
          angle_b2_i <= a.b2;
          angle_phi_i <= a.phi;
          angle_c1_i <= a.c1;
          angle_c2_i <= a.c2;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cosine_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_cosines.size() == 0) begin
          report_mismatch("unexpected result, component", component_o, -1);
        end else begin
          e = expected_cosines.pop_front();
          if (component_o !== e.comp) report_mismatch("component", component_o, e.comp);
          if (cosine_value_o !== e.value)
            report_mismatch("cosine", cosine_value_o, e.value);
          if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        end
        results_seen++;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int n_rand;
    n_rand = 400;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero, extremes, fold boundaries, saturation
    queue_angles(0, 0, 0, 0, 0);
    queue_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_angles(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_angles(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    queue_angles(12868, -12868, 12867, -12867, 12869);
    queue_angles(-12869, 12869, -12868, 12868, 0);
    queue_angles(25736, -25736, 6434, -6434, 25735);
    queue_angles(-1, 1, -1, 1, -1);
    queue_angles(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    queue_angles(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    queue_angles(0, 0, 16'sh7fff, 0, 16'sh8000);
    queue_angles(6434, 6434, 0, 6434, 6434);
    for (int i = 0; i < n_rand; i++)
      queue_angles(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle());
    // idling phases keyed on progress through the items
    wait (items_sent >= 140);
    send_idle_pct = 73;
    recv_idle_pct = 27;
    wait (items_sent >= 280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_angles.size() == 0 && !in_valid_i);
    wait (expected_cosines.size() == 0);
    repeat (500) @(posedge clk_i);
    $display("checked %0d angle sets, %0d cosines across three idling phases",
             items_sent, results_seen);
    if (errors == 0 && expected_cosines.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout after %0d results", results_seen);
    $display("Test completed with failures");
    $finish;
  end

endmodule
